// File: rtl/elastic_audio_ring_buffer_unit_defines.svh
// Assertion macros shared by the elastic audio ring buffer modules.
`ifndef ELASTIC_AUDIO_RING_BUFFER_UNIT_DEFINES_SVH
`define ELASTIC_AUDIO_RING_BUFFER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define EARB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define EARB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/earb_pkg.sv
// Types and constants shared by the elastic audio ring buffer modules.
package earb_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int LEN_W     = 7;
  localparam int MARK_W    = 7;
  localparam int FILL_W    = 7;
  localparam int FUNC_W    = 2;
  localparam int TOTAL_W   = 32;
  localparam int CFG_IDX_W = 2;

  // Command queue between front and back.
  localparam int QDEPTH = 4;
  localparam int QAW    = 2;
  localparam int QCW    = 3;

  // Function codes of an input transaction.
  localparam logic [FUNC_W-1:0] FUNC_PUSH    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_PULL    = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_RESTART = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW    = 2'd2;

  // Configuration reset values.
  localparam logic [MARK_W-1:0] TARGET_RST = 7'd64;
  localparam logic [MARK_W-1:0] HIGH_RST   = 7'd96;
  localparam logic [MARK_W-1:0] LOW_RST    = 7'd32;

  typedef enum logic [1:0] {
    CMD_PUSH,
    CMD_PULL,
    CMD_RESTART
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                   kind;
    logic signed [SAMPLE_W-1:0]  sample;
    logic        [LEN_W-1:0]     len;
  } cmd_t;

  typedef struct packed {
    logic push;
    cmd_t cmd;
  } q_wr_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic [MARK_W-1:0] target;
    logic [MARK_W-1:0] high;
    logic [MARK_W-1:0] low;
  } cfg_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_SETUP,
    B_EMIT
  } back_state_t;

endpackage

// File: rtl/earb_front.sv
// Front end: accepts input transactions, classifies them and queues commands.
module earb_front #(
  parameter int MAX_BLOCK = 64
) (
  input  earb_pkg::q_stat_t                    q_stat,
  input  logic                                 start,
  input  logic        [earb_pkg::FUNC_W-1:0]   in_func,
  input  logic signed [earb_pkg::SAMPLE_W-1:0] in_sample_in,
  input  logic        [earb_pkg::LEN_W-1:0]    in_block_length,
  output logic                                 busy,
  output earb_pkg::q_wr_t                      q_wr
);
  import earb_pkg::*;

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_BLOCK);

  logic accept;

  // A transaction is taken whenever the queue has room.
  assign accept = start && !q_stat.full;
  assign busy   = q_stat.full;

  // Classify the function code and clamp oversized blocks.
  always_comb begin
    q_wr.push       = 1'b0;
    q_wr.cmd.kind   = CMD_PUSH;
    q_wr.cmd.sample = in_sample_in;
    q_wr.cmd.len    = (in_block_length > MAX_LEN) ? MAX_LEN : in_block_length;
    case (in_func)
      FUNC_PUSH: begin
        q_wr.push = accept;
      end
      FUNC_PULL: begin
        // An empty block has no effect at all, so it is not queued.
        q_wr.cmd.kind = CMD_PULL;
        q_wr.push     = accept && (in_block_length != '0);
      end
      FUNC_RESTART: begin
        q_wr.cmd.kind = CMD_RESTART;
        q_wr.push     = accept;
      end
      default: begin
        q_wr.push = 1'b0;
      end
    endcase
  end

endmodule

// File: rtl/earb_cmd_fifo.sv
// Short command queue that decouples the front end from the back end.
`include "elastic_audio_ring_buffer_unit_defines.svh"

module earb_cmd_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  earb_pkg::q_wr_t   q_wr,
  input  logic              pop,
  output earb_pkg::q_stat_t q_stat,
  output earb_pkg::cmd_t    head
);
  import earb_pkg::*;

  cmd_t           q_r [QDEPTH];
  logic [QAW-1:0] wptr_r, wptr_nxt;
  logic [QAW-1:0] rptr_r, rptr_nxt;
  logic [QCW-1:0] cnt_r, cnt_nxt;

  // Pointer and occupancy update.
  always_comb begin
    wptr_nxt = q_wr.push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = pop ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r + QCW'(q_wr.push) - QCW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (q_wr.push) begin
      q_r[wptr_r] <= q_wr.cmd;
    end
  end

  assign head         = q_r[rptr_r];
  assign q_stat.full  = (cnt_r == QCW'(QDEPTH));
  assign q_stat.empty = (cnt_r == '0);

  `EARB_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_r <= QCW'(QDEPTH), "queue count above depth")
  `EARB_ASSERT_NOW(a_no_push_full, q_stat.full, !q_wr.push, "push into a full queue")
  `EARB_ASSERT_NOW(a_no_pop_empty, q_stat.empty, !pop, "pop from an empty queue")

endmodule

// File: rtl/earb_back.sv
// Back end: ring storage, priming and slip control, and sample emission.
`include "elastic_audio_ring_buffer_unit_defines.svh"

module earb_back #(
  parameter int RING_SIZE = 128
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  earb_pkg::cfg_t                        cfg,
  input  earb_pkg::cmd_t                        head,
  input  earb_pkg::q_stat_t                     q_stat,
  output logic                                  pop,
  output logic                                  out_valid,
  output logic signed [earb_pkg::SAMPLE_W-1:0]  out_sample_out,
  output logic                                  out_last_in_block,
  output logic                                  out_underrun_flag,
  output logic        [earb_pkg::FILL_W-1:0]    out_fill_depth,
  output logic        [earb_pkg::TOTAL_W-1:0]   out_underflow_total,
  output logic        [earb_pkg::TOTAL_W-1:0]   out_overflow_total
);
  import earb_pkg::*;

  localparam int IDXW = $clog2(RING_SIZE);
  localparam int CW   = (IDXW > LEN_W) ? IDXW : LEN_W;
  localparam logic [IDXW-1:0] IDX_LAST  = IDXW'(RING_SIZE - 1);
  localparam logic [IDXW:0]   DEPTH_EXT = (IDXW + 1)'(RING_SIZE);

  // Ring index advance with wrap at the ring depth.
  function automatic logic [IDXW-1:0] idx_next(input logic [IDXW-1:0] i);
    return (i == IDX_LAST) ? '0 : i + 1'b1;
  endfunction

  // Ring occupancy from the write and read indexes.
  function automatic logic [CW-1:0] fill_of(input logic [IDXW-1:0] w,
                                            input logic [IDXW-1:0] r);
    logic [IDXW:0] diff;
    diff = (w >= r) ? ({1'b0, w} - {1'b0, r}) : ({1'b0, w} + DEPTH_EXT - {1'b0, r});
    return CW'(diff[IDXW-1:0]);
  endfunction

  back_state_t state_r, state_nxt;

  logic signed [SAMPLE_W-1:0] mem [RING_SIZE];
  logic signed [SAMPLE_W-1:0] rdata_r;
  logic                       mem_we;

  logic [IDXW-1:0]            wr_idx_r, wr_idx_nxt;
  logic [IDXW-1:0]            rd_idx_r, rd_idx_nxt;
  logic signed [SAMPLE_W-1:0] last_r, last_nxt;
  logic                       primed_r, primed_nxt;
  logic [TOTAL_W-1:0]         ovf_r, ovf_nxt;
  logic [TOTAL_W-1:0]         udf_r, udf_nxt;
  logic [LEN_W-1:0]           cnt_r, cnt_nxt;
  logic                       silence_r, silence_nxt;
  logic                       insert_r, insert_nxt;

  logic                       out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_W-1:0] out_sample_r, out_sample_nxt;
  logic                       out_last_r, out_last_nxt;
  logic                       out_under_r, out_under_nxt;
  logic [FILL_W-1:0]          out_fill_r, out_fill_nxt;
  logic [TOTAL_W-1:0]         out_udf_r, out_udf_nxt;
  logic [TOTAL_W-1:0]         out_ovf_r, out_ovf_nxt;

  logic [CW-1:0]              depth;
  logic [CW-1:0]              depth_slip;
  logic [CW-1:0]              fill_now;
  logic                       ring_full;

  assign ring_full = (idx_next(wr_idx_r) == rd_idx_r);

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE: begin
        if (!q_stat.empty && head.kind == CMD_PULL) begin
          state_nxt = B_SETUP;
        end
      end
      B_SETUP: begin
        state_nxt = B_EMIT;
      end
      B_EMIT: begin
        if (cnt_r == LEN_W'(1)) begin
          state_nxt = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  // Datapath and output logic.
  always_comb begin
    pop            = 1'b0;
    mem_we         = 1'b0;
    wr_idx_nxt     = wr_idx_r;
    rd_idx_nxt     = rd_idx_r;
    last_nxt       = last_r;
    primed_nxt     = primed_r;
    ovf_nxt        = ovf_r;
    udf_nxt        = udf_r;
    cnt_nxt        = cnt_r;
    silence_nxt    = silence_r;
    insert_nxt     = insert_r;
    out_valid_nxt  = 1'b0;
    out_sample_nxt = out_sample_r;
    out_last_nxt   = out_last_r;
    out_under_nxt  = out_under_r;
    out_fill_nxt   = out_fill_r;
    out_udf_nxt    = out_udf_r;
    out_ovf_nxt    = out_ovf_r;
    depth          = fill_of(wr_idx_r, rd_idx_r);
    depth_slip     = depth;
    fill_now       = depth;
    case (state_r)
      B_IDLE: begin
        // Take one command from the queue and carry out pushes and restarts.
        if (!q_stat.empty) begin
          pop = 1'b1;
          case (head.kind)
            CMD_PUSH: begin
              if (ring_full) begin
                ovf_nxt = ovf_r + 1'b1;
              end else begin
                mem_we     = 1'b1;
                wr_idx_nxt = idx_next(wr_idx_r);
              end
            end
            CMD_PULL: begin
              cnt_nxt = head.len;
            end
            CMD_RESTART: begin
              wr_idx_nxt = '0;
              rd_idx_nxt = '0;
              last_nxt   = '0;
              primed_nxt = 1'b0;
            end
            default: begin
              pop = 1'b1;
            end
          endcase
        end
      end
      B_SETUP: begin
        // Decide priming, then at most one slip for the whole block.
        if (!primed_r && depth < CW'(cfg.target)) begin
          silence_nxt = 1'b1;
          insert_nxt  = 1'b0;
        end else begin
          silence_nxt = 1'b0;
          primed_nxt  = 1'b1;
          if (depth > CW'(cfg.high) && depth > CW'(cnt_r)) begin
            rd_idx_nxt = idx_next(rd_idx_r);
            depth_slip = depth - 1'b1;
          end
          insert_nxt = (depth_slip < CW'(cfg.low));
        end
      end
      B_EMIT: begin
        // One sample per cycle: silence, a repeat, a ring read or an underrun.
        out_valid_nxt = 1'b1;
        out_last_nxt  = (cnt_r == LEN_W'(1));
        out_under_nxt = 1'b0;
        cnt_nxt       = cnt_r - 1'b1;
        if (silence_r) begin
          out_sample_nxt = '0;
        end else if (insert_r) begin
          out_sample_nxt = last_r;
          insert_nxt     = 1'b0;
        end else if (rd_idx_r != wr_idx_r) begin
          out_sample_nxt = rdata_r;
          last_nxt       = rdata_r;
          rd_idx_nxt     = idx_next(rd_idx_r);
        end else begin
          out_sample_nxt = last_r;
          out_under_nxt  = 1'b1;
          udf_nxt        = udf_r + 1'b1;
          primed_nxt     = 1'b0;
        end
        fill_now     = fill_of(wr_idx_r, rd_idx_nxt);
        out_fill_nxt = fill_now[FILL_W-1:0];
        out_udf_nxt  = udf_nxt;
        out_ovf_nxt  = ovf_r;
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      wr_idx_r    <= '0;
      rd_idx_r    <= '0;
      last_r      <= '0;
      primed_r    <= 1'b0;
      ovf_r       <= '0;
      udf_r       <= '0;
      cnt_r       <= '0;
      silence_r   <= 1'b0;
      insert_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wr_idx_r    <= wr_idx_nxt;
      rd_idx_r    <= rd_idx_nxt;
      last_r      <= last_nxt;
      primed_r    <= primed_nxt;
      ovf_r       <= ovf_nxt;
      udf_r       <= udf_nxt;
      cnt_r       <= cnt_nxt;
      silence_r   <= silence_nxt;
      insert_r    <= insert_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload registers.
  always_ff @(posedge clk) begin
    out_sample_r <= out_sample_nxt;
    out_last_r   <= out_last_nxt;
    out_under_r  <= out_under_nxt;
    out_fill_r   <= out_fill_nxt;
    out_udf_r    <= out_udf_nxt;
    out_ovf_r    <= out_ovf_nxt;
  end

  // Sample ring: write on push, registered read of the next read index.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_idx_r] <= head.sample;
    end
    rdata_r <= mem[rd_idx_nxt];
  end

  assign out_valid           = out_valid_r;
  assign out_sample_out      = out_sample_r;
  assign out_last_in_block   = out_last_r;
  assign out_underrun_flag   = out_under_r;
  assign out_fill_depth      = out_fill_r;
  assign out_underflow_total = out_udf_r;
  assign out_overflow_total  = out_ovf_r;

  `EARB_ASSERT_NEXT(a_emit_strobe, state_r == B_EMIT, out_valid_r, "emit cycle gave no strobe")
  `EARB_ASSERT_NEXT(a_quiet_strobe, state_r != B_EMIT, !out_valid_r, "strobe outside emission")
  `EARB_ASSERT_NEXT(a_sil_udf, (state_r == B_EMIT) && silence_r, $stable(udf_r), "udf in silence")
  `EARB_ASSERT_NOW(a_last_idle, out_valid_r && out_last_r, state_r == B_IDLE, "late block end")

endmodule

// File: rtl/elastic_audio_ring_buffer_unit.sv
// Top level of the elastic audio ring buffer with watermark slip.
//
// Usage: a command is taken on a clock edge with start high and busy low. Pushes,
// restarts and pulls go into a four-entry command queue, and busy is high only
// while that queue is full. The back end carries out a push or a restart as it
// dequeues it; a pull of len samples is dequeued, then priming and slip are
// decided, then one sample per cycle is emitted. Samples leave on the out_ ports,
// each for exactly one cycle with out_valid high; the receiver cannot stall them,
// so it must take every strobed sample. The sample ring is a single memory with
// one write and one registered read per cycle, needs no clearing after reset, and
// holds at most RING_SIZE - 1 samples. Configuration writes are always ready and
// take effect for the next pull; write them while no command is pending.
module elastic_audio_ring_buffer_unit #(
  parameter int RING_SIZE = 128,
  parameter int MAX_BLOCK = 64
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic        [earb_pkg::FUNC_W-1:0]    in_func,
  input  logic signed [earb_pkg::SAMPLE_W-1:0]  in_sample_in,
  input  logic        [earb_pkg::LEN_W-1:0]     in_block_length,
  output logic                                  out_valid,
  output logic signed [earb_pkg::SAMPLE_W-1:0]  out_sample_out,
  output logic                                  out_last_in_block,
  output logic                                  out_underrun_flag,
  output logic        [earb_pkg::FILL_W-1:0]    out_fill_depth,
  output logic        [earb_pkg::TOTAL_W-1:0]   out_underflow_total,
  output logic        [earb_pkg::TOTAL_W-1:0]   out_overflow_total,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic        [earb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic        [earb_pkg::MARK_W-1:0]    cfg_data
);
  import earb_pkg::*;

  cfg_t    cfg_r, cfg_nxt;
  q_wr_t   q_wr;
  q_stat_t q_stat;
  cmd_t    head;
  logic    pop;

  // Configuration registers, always ready for a write transaction.
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_TARGET: cfg_nxt.target = cfg_data;
        CFG_HIGH:   cfg_nxt.high   = cfg_data;
        CFG_LOW:    cfg_nxt.low    = cfg_data;
        default:    cfg_nxt        = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target <= TARGET_RST;
      cfg_r.high   <= HIGH_RST;
      cfg_r.low    <= LOW_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  earb_front #(
    .MAX_BLOCK (MAX_BLOCK)
  ) u_front (
    .q_stat          (q_stat),
    .start           (start),
    .in_func         (in_func),
    .in_sample_in    (in_sample_in),
    .in_block_length (in_block_length),
    .busy            (busy),
    .q_wr            (q_wr)
  );

  earb_cmd_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_wr   (q_wr),
    .pop    (pop),
    .q_stat (q_stat),
    .head   (head)
  );

  earb_back #(
    .RING_SIZE (RING_SIZE)
  ) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg                 (cfg_r),
    .head                (head),
    .q_stat              (q_stat),
    .pop                 (pop),
    .out_valid           (out_valid),
    .out_sample_out      (out_sample_out),
    .out_last_in_block   (out_last_in_block),
    .out_underrun_flag   (out_underrun_flag),
    .out_fill_depth      (out_fill_depth),
    .out_underflow_total (out_underflow_total),
    .out_overflow_total  (out_overflow_total)
  );

endmodule
